// ----- sv/fkhp_pkg.sv -----
package fkhp_pkg;

    // Packet length limit and byte counter width
    localparam int MAX_PACKET_BYTES = 65535;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    // Link header codes
    localparam logic [1:0] LINK_NULL   = 2'd0;
    localparam logic [1:0] LINK_ETH    = 2'd1;
    localparam logic [1:0] LINK_COOKED = 2'd2;
    localparam logic [1:0] LINK_NONE   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LINK  = 3'd1;
    localparam logic [2:0] ST_SHORT_HDR = 3'd2;
    localparam logic [2:0] ST_FRAGMENT  = 3'd3;
    localparam logic [2:0] ST_OVERRUN   = 3'd4;
    localparam logic [2:0] ST_SHORT_PKT = 3'd5;
    localparam logic [2:0] ST_BAD_VER   = 3'd6;
    localparam logic [2:0] ST_TRUNC     = 3'd7;

    // Ethertypes
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [15:0] ETH_VLAN  = 16'h8100;
    localparam logic [15:0] ETH_MPLS  = 16'h8847;
    localparam logic [15:0] ETH_PPPOE = 16'h8864;

    // IP constants
    localparam logic [3:0]  IP_VER4      = 4'd4;
    localparam logic [3:0]  IP_VER6      = 4'd6;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_DSTOPT = 8'd60;
    localparam logic [15:0] FRAG_MASK    = 16'h3FFF;
    localparam logic [15:0] IPV4_MIN     = 16'd20;
    localparam logic [15:0] IPV6_MIN     = 16'd40;
    localparam logic [15:0] IPV6_OPT_MIN = 16'd42;
    localparam logic [15:0] TCP_MIN      = 16'd20;
    localparam logic [15:0] UDP_MIN      = 16'd8;

    // Parse phases
    localparam logic [2:0] PH_LINK  = 3'd0;
    localparam logic [2:0] PH_VLAN  = 3'd1;
    localparam logic [2:0] PH_MPLS  = 3'd2;
    localparam logic [2:0] PH_PPPOE = 3'd3;
    localparam logic [2:0] PH_IP    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  ip_version;
        logic [7:0]  protocol;
        logic [11:0] vlan_id;
        logic [63:0] lower_addr_high;
        logic [63:0] lower_addr_low;
        logic [63:0] upper_addr_high;
        logic [63:0] upper_addr_low;
        logic [15:0] lo_port;
        logic [15:0] hi_port;
        logic [47:0] lo_mac;
        logic [47:0] hi_mac;
    } t_out;

    // Per-link parse state
    typedef struct packed {
        logic [2:0]   phase;
        logic [15:0]  rel;       // bytes seen in current header
        logic [15:0]  typ;
        logic         zero_fam;
        logic [11:0]  vlan;
        logic         bos;
        logic [3:0]   ver;
        logic [3:0]   ihl;
        logic [15:0]  ln;        // v4 total length or v6 payload length
        logic [15:0]  frag;
        logic [7:0]   proto;
        logic [7:0]   nh;
        logic [11:0]  q;         // port offset from IP start
        logic         q_ok;
        logic [127:0] src;
        logic [127:0] dst;
        logic [31:0]  ports;
        logic         port_done;
    } t_lane_st;

    typedef struct packed {
        t_lane_st    st;
        logic        ovl;
        logic [1:0]  link_type;
        logic [47:0] dmac;
        logic [47:0] smac;
    } t_snap;

endpackage

// ----- sv/fkhp_lane.sv -----
module fkhp_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_link_type,
    input  logic               i_beat,
    input  logic               i_keep,
    input  logic               i_last,
    input  logic [7:0]         i_byte,
    output fkhp_pkg::t_lane_st o_next
);
    import fkhp_pkg::*;

    t_lane_st    r_st;
    t_lane_st    n_st;
    logic [15:0] idx;
    logic        disp;
    logic [11:0] q_cur;
    logic        q_ok_cur;
    logic [16:0] diff;

    // Next state for one stored byte
    always_comb begin
        n_st     = r_st;
        idx      = r_st.rel;
        n_st.rel = r_st.rel + 16'd1;
        disp     = 1'b0;
        q_cur    = (idx == 16'd0) ? {6'b0, i_byte[3:0], 2'b0} : r_st.q;
        q_ok_cur = (idx == 16'd0) ? (i_byte[7:4] == IP_VER4) : r_st.q_ok;
        diff     = {1'b0, idx} - {5'b0, q_cur};

        unique case (r_st.phase)
            PH_LINK: begin
                n_st.typ = {r_st.typ[7:0], i_byte};
                case (i_link_type)
                    LINK_NULL: begin
                        if (idx < 16'd3) begin
                            n_st.zero_fam = r_st.zero_fam && (i_byte == 8'd0);
                        end
                        if (idx == 16'd3) begin
                            n_st.typ = (r_st.zero_fam && i_byte == 8'd2) ? ETH_IPV4 : ETH_IPV6;
                            disp     = 1'b1;
                        end
                    end
                    LINK_ETH:    disp = (idx == 16'd13);
                    LINK_COOKED: disp = (idx == 16'd15);
                    default: ;
                endcase
            end
            PH_VLAN: begin
                if (idx == 16'd0) n_st.vlan[11:8] = i_byte[3:0];
                if (idx == 16'd1) n_st.vlan[7:0]  = i_byte;
                if (idx == 16'd2 || idx == 16'd3) n_st.typ = {r_st.typ[7:0], i_byte};
                disp = (idx == 16'd3);
            end
            PH_MPLS: begin
                // bottom-of-stack bit sits in the third label byte
                if (idx == 16'd2) n_st.bos = i_byte[0];
                if (idx == 16'd3) begin
                    n_st.rel = 16'd0;
                    n_st.bos = 1'b0;
                    if (r_st.bos) n_st.phase = PH_IP;
                end
            end
            PH_PPPOE: begin
                if (idx == 16'd7) begin
                    n_st.rel   = 16'd0;
                    n_st.phase = PH_IP;
                end
            end
            PH_IP: begin
                if (idx == 16'd0) begin
                    n_st.ver  = i_byte[7:4];
                    n_st.ihl  = i_byte[3:0];
                    n_st.q    = q_cur;
                    n_st.q_ok = q_ok_cur;
                end else if (r_st.ver == IP_VER4) begin
                    if (idx == 16'd2 || idx == 16'd3) n_st.ln   = {r_st.ln[7:0], i_byte};
                    if (idx == 16'd6 || idx == 16'd7) n_st.frag = {r_st.frag[7:0], i_byte};
                    if (idx == 16'd9) n_st.proto = i_byte;
                    if (idx >= 16'd12 && idx < 16'd16) n_st.src = {r_st.src[119:0], i_byte};
                    if (idx >= 16'd16 && idx < 16'd20) n_st.dst = {r_st.dst[119:0], i_byte};
                end else if (r_st.ver == IP_VER6) begin
                    if (idx == 16'd4 || idx == 16'd5) n_st.ln = {r_st.ln[7:0], i_byte};
                    if (idx == 16'd6) begin
                        n_st.proto = i_byte;
                        if (i_byte != PROTO_DSTOPT) begin
                            n_st.q    = 12'd40;
                            n_st.q_ok = 1'b1;
                        end
                    end
                    if (idx >= 16'd8 && idx < 16'd24)  n_st.src = {r_st.src[119:0], i_byte};
                    if (idx >= 16'd24 && idx < 16'd40) n_st.dst = {r_st.dst[119:0], i_byte};
                    if (idx == 16'd40) n_st.nh = i_byte;
                    if (idx == 16'd41 && r_st.proto == PROTO_DSTOPT) begin
                        n_st.q    = 12'd48 + {1'b0, i_byte, 3'b0};
                        n_st.q_ok = 1'b1;
                    end
                end
                // transport port bytes
                if (q_ok_cur && !diff[16] && diff[15:2] == 14'd0) begin
                    n_st.ports = {r_st.ports[23:0], i_byte};
                    if (diff[1:0] == 2'd3) n_st.port_done = 1'b1;
                end
            end
            default: ;
        endcase

        // encapsulation dispatch on the ethertype just completed
        if (disp) begin
            n_st.rel = 16'd0;
            case (n_st.typ)
                ETH_VLAN:  n_st.phase = PH_VLAN;
                ETH_MPLS:  n_st.phase = PH_MPLS;
                ETH_PPPOE: n_st.phase = PH_PPPOE;
                default:   n_st.phase = PH_IP;
            endcase
        end
    end

    // State register, restarts on every last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            r_st.phase     <= PH_LINK;
            r_st.rel       <= 16'd0;
            r_st.zero_fam  <= 1'b1;
            r_st.vlan      <= 12'd0;
            r_st.bos       <= 1'b0;
            r_st.q_ok      <= 1'b0;
            r_st.port_done <= 1'b0;
        end else if (i_beat && i_keep) begin
            r_st <= n_st;
        end
    end

    assign o_next = n_st;

endmodule

// ----- sv/flow_key_header_parser_top.sv -----
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_in_data (t_in), one packet byte per beat
// out      output     o_out_valid / i_out_ready   o_out_data (t_out), one flow key per packet
// cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_data, link type
//
// One byte per cycle is taken when not stalled. Three parse lanes (null, Ethernet, cooked) follow
// every byte; the last beat snapshots the lane picked by the link type.
// The key is formed from the snapshot into the output register once that register is free.
// Input beats stall only while the snapshot and output register are full and i_out_ready is low.
// Synchronous active-low reset: link type Ethernet, no packet in progress.
module flow_key_header_parser_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fkhp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fkhp_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_data
);
    import fkhp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic             r_ovl;
    logic             n_ovl;
    logic [47:0]      r_dmac;
    logic [47:0]      r_smac;
    logic [1:0]       r_link_type;
    t_snap            r_snap;
    logic             r_snap_v;
    t_out             r_out;
    logic             r_out_v;
    logic             beat;
    logic             snap_move;
    t_lane_st         lane_next [3];
    t_lane_st         sel_st;
    t_out             fin;

    // Handshakes
    assign snap_move   = r_snap_v && (!r_out_v || i_out_ready);
    assign o_in_ready  = !r_snap_v || snap_move;
    assign beat        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign n_ovl       = r_ovl || (r_pos == POS_W'(MAX_PACKET_BYTES));

    // Parse lanes, one per supported link header
    for (genvar g = 0; g < 3; g++) begin : g_lane
        fkhp_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_link_type (2'(g)),
            .i_beat      (beat),
            .i_keep      (!n_ovl),
            .i_last      (i_in_data.last_byte),
            .i_byte      (i_in_data.data_byte),
            .o_next      (lane_next[g])
        );
    end

    always_comb begin
        case (r_link_type)
            LINK_NULL:   sel_st = lane_next[0];
            LINK_COOKED: sel_st = lane_next[2];
            default:     sel_st = lane_next[1];
        endcase
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_type <= LINK_ETH;
        end else if (i_cfg_valid) begin
            r_link_type <= i_cfg_data;
        end
    end

    // Byte position, over-long flag, MAC capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ovl <= 1'b0;
        end else if (beat) begin
            if (i_in_data.last_byte) begin
                r_pos <= '0;
                r_ovl <= 1'b0;
            end else if (!n_ovl) begin
                r_pos <= r_pos + POS_W'(1);
            end else begin
                r_ovl <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat && !n_ovl) begin
            if (r_pos < POS_W'(6)) begin
                r_dmac <= {r_dmac[39:0], i_in_data.data_byte};
            end else if (r_pos < POS_W'(12)) begin
                r_smac <= {r_smac[39:0], i_in_data.data_byte};
            end
        end
    end

    // Snapshot at last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_v <= 1'b0;
        end else if (beat && i_in_data.last_byte) begin
            r_snap_v <= 1'b1;
        end else if (snap_move) begin
            r_snap_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat && i_in_data.last_byte) begin
            r_snap.st        <= sel_st;
            r_snap.ovl       <= n_ovl;
            r_snap.link_type <= r_link_type;
            r_snap.dmac      <= (r_pos < POS_W'(6)) ? {r_dmac[39:0], i_in_data.data_byte}
                                                    : r_dmac;
            r_snap.smac      <= (r_pos >= POS_W'(6) && r_pos < POS_W'(12))
                                ? {r_smac[39:0], i_in_data.data_byte} : r_smac;
        end
    end

    // Key formation: status checks, endpoint ordering
    logic [15:0]  avail;
    logic [15:0]  iplen;
    logic [15:0]  l4;
    logic [7:0]   proto_f;
    logic         is_v6;
    logic [127:0] a_src;
    logic [127:0] a_dst;
    logic         src_lt;
    logic         src_eq;
    logic         need_ports;
    logic [2:0]   st;
    logic [15:0]  sp;
    logic [15:0]  dp;

    always_comb begin
        avail   = r_snap.st.rel;
        iplen   = {10'b0, r_snap.st.ihl, 2'b0};
        is_v6   = (r_snap.st.ver == IP_VER6);
        proto_f = (is_v6 && r_snap.st.proto == PROTO_DSTOPT) ? r_snap.st.nh : r_snap.st.proto;
        if (is_v6) begin
            l4 = r_snap.st.ln;
        end else begin
            l4 = (r_snap.st.ln > iplen) ? (r_snap.st.ln - iplen) : 16'd0;
        end
        a_src  = is_v6 ? r_snap.st.src : {96'b0, r_snap.st.src[31:0]};
        a_dst  = is_v6 ? r_snap.st.dst : {96'b0, r_snap.st.dst[31:0]};
        src_lt = (a_src < a_dst);
        src_eq = (a_src == a_dst);
        need_ports = (proto_f == PROTO_TCP && l4 >= TCP_MIN)
                  || (proto_f == PROTO_UDP && l4 >= UDP_MIN);
        sp = r_snap.st.ports[31:16];
        dp = r_snap.st.ports[15:0];

        // packet ending right at the IP header start has no version byte
        st = ST_OK;
        if (r_snap.ovl) begin
            st = ST_TRUNC;
        end else if (r_snap.link_type == LINK_NONE) begin
            st = ST_BAD_LINK;
        end else if (r_snap.st.phase != PH_IP || avail == 16'd0) begin
            st = ST_TRUNC;
        end else if (r_snap.st.ver == IP_VER4) begin
            if (avail < IPV4_MIN) st = ST_SHORT_HDR;
            else if ((r_snap.st.frag & FRAG_MASK) != 16'd0) st = ST_FRAGMENT;
            else if (iplen > avail) st = ST_OVERRUN;
            else if (avail < r_snap.st.ln) st = ST_SHORT_PKT;
        end else if (is_v6) begin
            if (avail < IPV6_MIN) st = ST_SHORT_HDR;
            else if (r_snap.st.proto == PROTO_DSTOPT && avail < IPV6_OPT_MIN) st = ST_TRUNC;
        end else begin
            st = ST_BAD_VER;
        end
        if (st == ST_OK && need_ports && !r_snap.st.port_done) begin
            st = ST_TRUNC;
        end

        fin        = '0;
        fin.status = st;
        if (st == ST_OK) begin
            fin.ip_version      = r_snap.st.ver;
            fin.protocol        = proto_f;
            fin.vlan_id         = r_snap.st.vlan;
            fin.lower_addr_high = src_lt ? a_src[127:64] : a_dst[127:64];
            fin.lower_addr_low  = src_lt ? a_src[63:0]   : a_dst[63:0];
            fin.upper_addr_high = src_lt ? a_dst[127:64] : a_src[127:64];
            fin.upper_addr_low  = src_lt ? a_dst[63:0]   : a_src[63:0];
            if (need_ports) begin
                if (src_lt || (src_eq && proto_f == PROTO_TCP && dp > sp)) begin
                    fin.lo_port = sp;
                    fin.hi_port = dp;
                end else begin
                    fin.lo_port = dp;
                    fin.hi_port = sp;
                end
            end
            if (r_snap.link_type == LINK_ETH) begin
                fin.lo_mac = src_lt ? r_snap.smac : r_snap.dmac;
                fin.hi_mac = src_lt ? r_snap.dmac : r_snap.smac;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (snap_move) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_out <= fin;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Checks
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_link_type == LINK_ETH && !o_out_valid && !r_snap_v))
        else $error("reset state wrong");

    a_no_snap_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_v && !snap_move) |-> !(beat && i_in_data.last_byte))
        else $error("snapshot overwritten");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.lower_addr_low == 64'd0 && o_out_data.upper_addr_low == 64'd0
         && o_out_data.lo_port == 16'd0 && o_out_data.lo_mac == 48'd0))
        else $error("error key not cleared");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_OK) |->
        ({o_out_data.lower_addr_high, o_out_data.lower_addr_low}
         <= {o_out_data.upper_addr_high, o_out_data.upper_addr_low}))
        else $error("endpoints out of order");

endmodule
